// File: sv/blsc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package blsc_pkg;

   localparam int MAX_GRID_CELLS_DEF   = 16;
   localparam int GAIN_FRAC_BITS_DEF   = 13;
   localparam int OFFSET_FRAC_BITS_DEF = 12;

   localparam int PIX_W      = 16;
   localparam int GAIN_W     = 16;
   localparam int IDX_W      = 11;
   localparam int POS_W      = 13;
   localparam int DIM_W      = 14;
   localparam int GRID_W     = 5;
   localparam int BITS_W     = 5;
   localparam int FRAME_MAX  = 8192;
   localparam int MAX_BITS   = 16;
   localparam int CFG_ADDR_W = 5;
   localparam int CFG_DATA_W = 32;
   localparam int REQ_DATA_W = 48;

   localparam logic CMD_NODE  = 1'b0;
   localparam logic CMD_PIXEL = 1'b1;

   typedef enum logic [2:0] {
      REG_ENABLE        = 3'd0,
      REG_BAYER_PATTERN = 3'd1,
      REG_FRAME_WIDTH   = 3'd2,
      REG_FRAME_HEIGHT  = 3'd3,
      REG_GRID_COLS     = 3'd4,
      REG_GRID_ROWS     = 3'd5,
      REG_PIXEL_BITS    = 3'd6
   } reg_index_type;

   typedef enum logic [2:0] {
      MS_TOP0  = 3'd0,
      MS_TOP1  = 3'd1,
      MS_BOT0  = 3'd2,
      MS_BOT1  = 3'd3,
      MS_SUM0  = 3'd4,
      MS_SUM1  = 3'd5,
      MS_PROD0 = 3'd6,
      MS_PROD1 = 3'd7
   } mstep_type;

   typedef struct packed {
      logic              enable;
      logic [1:0]        bayer_pattern;
      logic [DIM_W-1:0]  frame_width;
      logic [DIM_W-1:0]  frame_height;
      logic [GRID_W-1:0] grid_cols;
      logic [GRID_W-1:0] grid_rows;
      logic [BITS_W-1:0] pixel_bits;
   } cfg_type;

   typedef struct packed {
      logic      load;
      logic      node_wr;
      logic      div_step;
      logic      calc_addr;
      logic      rd_en;
      logic [1:0] rd_sel;
      logic      gain_shift;
      logic      mul_en;
      mstep_type mstep;
      logic      out_load;
   } ctl_cmd_type;

   typedef struct packed {
      logic bypass;
      logic out_full;
   } ctl_stat_type;

   // Channel order R, GR, GB, B; the site index is odd_row*2 + odd_col.
   function automatic logic [1:0] chan_sel(logic [1:0] pattern, logic [1:0] site);
      logic [1:0] flip;
      unique case (pattern)
         2'd0:    flip = 2'd0;
         2'd1:    flip = 2'd1;
         2'd2:    flip = 2'd3;
         default: flip = 2'd2;
      endcase
      return site ^ flip;
   endfunction

endpackage
`default_nettype wire

// File: sv/blsc_ram.sv
`timescale 1ns / 1ps
`default_nettype none
module blsc_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1156
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule
`default_nettype wire

// File: sv/blsc_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
module blsc_ctrl #(
   parameter int MAX_GRID_CELLS   = blsc_pkg::MAX_GRID_CELLS_DEF,
   parameter int OFFSET_FRAC_BITS = blsc_pkg::OFFSET_FRAC_BITS_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   input  wire logic                   req_cmd,
   output logic                        req_ready,
   input  wire logic                   rsp_ready,
   input  wire blsc_pkg::ctl_stat_type stat,
   output blsc_pkg::ctl_cmd_type       cmd
);

   localparam int CW   = $clog2(MAX_GRID_CELLS + 1);
   localparam int QW   = blsc_pkg::POS_W + CW + OFFSET_FRAC_BITS;
   localparam int CNTW = $clog2(QW);

   typedef enum logic [6:0] {
      ST_IDLE = 7'b0000001,
      ST_DIV  = 7'b0000010,
      ST_ADDR = 7'b0000100,
      ST_RD   = 7'b0001000,
      ST_RDW  = 7'b0010000,
      ST_MUL  = 7'b0100000,
      ST_OUT  = 7'b1000000
   } state_type;

   state_type        state_ff, state_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_cmd == blsc_pkg::CMD_NODE) begin
                  cmd.node_wr = 1'b1;
               end else begin
                  cmd.load = 1'b1;
                  cnt_in   = CNTW'(QW - 1);
                  state_in = stat.bypass ? ST_OUT : ST_DIV;
               end
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (cnt_ff == '0) begin
               state_in = ST_ADDR;
            end else begin
               cnt_in = cnt_ff - 1'b1;
            end
         end
         ST_ADDR: begin
            cmd.calc_addr = 1'b1;
            cnt_in        = '0;
            state_in      = ST_RD;
         end
         ST_RD: begin
            cmd.rd_en      = 1'b1;
            cmd.rd_sel     = cnt_ff[1:0];
            cmd.gain_shift = (cnt_ff != '0);
            if (cnt_ff[1:0] == 2'd3) begin
               state_in = ST_RDW;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_RDW: begin
            cmd.gain_shift = 1'b1;
            cnt_in         = '0;
            state_in       = ST_MUL;
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            cmd.mstep  = blsc_pkg::mstep_type'(cnt_ff[2:0]);
            if (cnt_ff[2:0] == 3'd7) begin
               state_in = ST_OUT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_OUT: begin
            if (!stat.out_full || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule
`default_nettype wire

// File: sv/blsc_dpath.sv
`timescale 1ns / 1ps
`default_nettype none
module blsc_dpath #(
   parameter int MAX_GRID_CELLS   = blsc_pkg::MAX_GRID_CELLS_DEF,
   parameter int GAIN_FRAC_BITS   = blsc_pkg::GAIN_FRAC_BITS_DEF,
   parameter int OFFSET_FRAC_BITS = blsc_pkg::OFFSET_FRAC_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire blsc_pkg::cfg_type             cfg,
   input  wire blsc_pkg::ctl_cmd_type         cmd,
   output blsc_pkg::ctl_stat_type             stat,
   input  wire logic [blsc_pkg::IDX_W-1:0]    node_index,
   input  wire logic [blsc_pkg::GAIN_W-1:0]   node_gain,
   input  wire logic [blsc_pkg::PIX_W-1:0]    pixel_in,
   input  wire logic                          rsp_ready,
   output logic                               rsp_valid,
   output logic      [blsc_pkg::PIX_W-1:0]    pixel_out,
   output logic                               clipped,
   output logic                               frame_end
);

   localparam int F      = OFFSET_FRAC_BITS;
   localparam int CW     = $clog2(MAX_GRID_CELLS + 1);
   localparam int PW     = CW + 1;
   localparam int TW     = blsc_pkg::POS_W + CW;
   localparam int QW     = TW + F;
   localparam int DW     = blsc_pkg::DIM_W;
   localparam int DEPTH  = 4 * (MAX_GRID_CELLS + 1) * (MAX_GRID_CELLS + 1);
   localparam int AW     = $clog2(DEPTH);
   localparam int GW     = blsc_pkg::GAIN_W;
   localparam int TOPW   = GW + F + 1;
   localparam int SUMW   = GW + 2 * F + 1;
   localparam int LOW    = SUMW / 2;
   localparam int PRODW  = blsc_pkg::PIX_W + SUMW;
   localparam int SH     = 2 * F + GAIN_FRAC_BITS;
   localparam int VW     = PRODW - SH;

   // Effective frame and grid sizes
   logic [DW-1:0] w_eff, h_eff;
   logic [CW-1:0] gc_eff, gr_eff;
   logic [PW-1:0] pitch, rows1;
   logic          bypass;

   always_comb begin
      if (cfg.frame_width == '0) w_eff = DW'(1);
      else if (32'(cfg.frame_width) > blsc_pkg::FRAME_MAX) w_eff = DW'(blsc_pkg::FRAME_MAX);
      else w_eff = cfg.frame_width;
      if (cfg.frame_height == '0) h_eff = DW'(1);
      else if (32'(cfg.frame_height) > blsc_pkg::FRAME_MAX) h_eff = DW'(blsc_pkg::FRAME_MAX);
      else h_eff = cfg.frame_height;
      gc_eff = (32'(cfg.grid_cols) > MAX_GRID_CELLS) ? CW'(MAX_GRID_CELLS)
                                                     : CW'(cfg.grid_cols);
      gr_eff = (32'(cfg.grid_rows) > MAX_GRID_CELLS) ? CW'(MAX_GRID_CELLS)
                                                     : CW'(cfg.grid_rows);
      pitch  = PW'(gc_eff) + PW'(1);
      rows1  = PW'(gr_eff) + PW'(1);
      bypass = !cfg.enable || (gc_eff == '0) || (gr_eff == '0);
   end

   // Position counters and per-pixel capture
   logic [blsc_pkg::POS_W-1:0] col_ff, col_in, row_ff, row_in;
   logic [blsc_pkg::PIX_W-1:0] pix_ff;
   logic                       bypass_ff, fend_ff;
   logic [1:0]                 ch_ff;
   logic [DW-1:0]              col_p1, row_p1;

   always_comb begin
      col_p1 = DW'(col_ff) + DW'(1);
      row_p1 = DW'(row_ff) + DW'(1);
      col_in = col_ff;
      row_in = row_ff;
      if (cmd.load) begin
         if (col_p1 >= w_eff) begin
            col_in = '0;
            row_in = (row_p1 >= h_eff) ? '0 : row_p1[blsc_pkg::POS_W-1:0];
         end else begin
            col_in = col_p1[blsc_pkg::POS_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Restoring dividers, one quotient bit per cycle on each axis
   logic [QW-1:0] dvd_x_ff, dvd_y_ff, q_x_ff, q_y_ff;
   logic [DW-1:0] rem_x_ff, rem_y_ff;
   logic [DW:0]   trial_x, trial_y;

   always_comb begin
      trial_x = {rem_x_ff, dvd_x_ff[QW-1]};
      trial_y = {rem_y_ff, dvd_y_ff[QW-1]};
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         pix_ff    <= pixel_in;
         bypass_ff <= bypass;
         fend_ff   <= (col_p1 >= w_eff) && (row_p1 >= h_eff);
         ch_ff     <= blsc_pkg::chan_sel(cfg.bayer_pattern, {row_ff[0], col_ff[0]});
         dvd_x_ff  <= {TW'(col_ff) * TW'(gc_eff), {F{1'b0}}};
         dvd_y_ff  <= {TW'(row_ff) * TW'(gr_eff), {F{1'b0}}};
         rem_x_ff  <= '0;
         rem_y_ff  <= '0;
         q_x_ff    <= '0;
         q_y_ff    <= '0;
      end else if (cmd.div_step) begin
         dvd_x_ff <= dvd_x_ff << 1;
         dvd_y_ff <= dvd_y_ff << 1;
         if (trial_x >= {1'b0, w_eff}) begin
            rem_x_ff <= DW'(trial_x - {1'b0, w_eff});
            q_x_ff   <= {q_x_ff[QW-2:0], 1'b1};
         end else begin
            rem_x_ff <= trial_x[DW-1:0];
            q_x_ff   <= {q_x_ff[QW-2:0], 1'b0};
         end
         if (trial_y >= {1'b0, h_eff}) begin
            rem_y_ff <= DW'(trial_y - {1'b0, h_eff});
            q_y_ff   <= {q_y_ff[QW-2:0], 1'b1};
         end else begin
            rem_y_ff <= trial_y[DW-1:0];
            q_y_ff   <= {q_y_ff[QW-2:0], 1'b0};
         end
      end
   end

   // Cell clamp and table base address
   logic [CW-1:0] cx, cy;
   logic [F-1:0]  dx, dy, dx_ff, dy_ff;
   logic [AW-1:0] base_ff, rd_addr;

   always_comb begin
      if (q_x_ff[QW-1:F] >= TW'(gc_eff)) begin
         cx = gc_eff - CW'(1);
         dx = '1;
      end else begin
         cx = CW'(q_x_ff[QW-1:F]);
         dx = q_x_ff[F-1:0];
      end
      if (q_y_ff[QW-1:F] >= TW'(gr_eff)) begin
         cy = gr_eff - CW'(1);
         dy = '1;
      end else begin
         cy = CW'(q_y_ff[QW-1:F]);
         dy = q_y_ff[F-1:0];
      end
      rd_addr = base_ff + (cmd.rd_sel[1] ? AW'(pitch) : AW'(0)) + AW'(cmd.rd_sel[0]);
   end

   always_ff @(posedge clock) begin
      if (cmd.calc_addr) begin
         dx_ff   <= dx;
         dy_ff   <= dy;
         base_ff <= AW'(ch_ff) * AW'(pitch) * AW'(rows1) + AW'(cy) * AW'(pitch) + AW'(cx);
      end
   end

   // Gain table
   logic [GW-1:0] rd_data;
   logic [GW-1:0] g_ff [4];

   blsc_ram #(
      .WIDTH (GW),
      .DEPTH (DEPTH)
   ) u_grid (
      .clock   (clock),
      .wr_en   (cmd.node_wr && (32'(node_index) < DEPTH)),
      .wr_addr (AW'(node_index)),
      .wr_data (node_gain),
      .rd_en   (cmd.rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (cmd.gain_shift) begin
         g_ff[0] <= g_ff[1];
         g_ff[1] <= g_ff[2];
         g_ff[2] <= g_ff[3];
         g_ff[3] <= rd_data;
      end
   end

   // Bilinear blend and pixel product, one multiply per cycle
   logic [F:0]       wx0, wy0;
   logic [TOPW-1:0]  top_ff, bot_ff;
   logic [SUMW-1:0]  sum_ff;
   logic [PRODW-1:0] prod_ff;

   always_comb begin
      wx0 = {1'b1, {F{1'b0}}} - {1'b0, dx_ff};
      wy0 = {1'b1, {F{1'b0}}} - {1'b0, dy_ff};
   end

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         unique case (cmd.mstep)
            blsc_pkg::MS_TOP0:  top_ff <= TOPW'(g_ff[0]) * TOPW'(wx0);
            blsc_pkg::MS_TOP1:  top_ff <= top_ff + TOPW'(g_ff[1]) * TOPW'(dx_ff);
            blsc_pkg::MS_BOT0:  bot_ff <= TOPW'(g_ff[2]) * TOPW'(wx0);
            blsc_pkg::MS_BOT1:  bot_ff <= bot_ff + TOPW'(g_ff[3]) * TOPW'(dx_ff);
            blsc_pkg::MS_SUM0:  sum_ff <= SUMW'(top_ff) * SUMW'(wy0);
            blsc_pkg::MS_SUM1:  sum_ff <= sum_ff + SUMW'(bot_ff) * SUMW'(dy_ff);
            blsc_pkg::MS_PROD0: prod_ff <= PRODW'(pix_ff) * PRODW'(sum_ff[LOW-1:0]);
            blsc_pkg::MS_PROD1: prod_ff <= prod_ff
                                   + ((PRODW'(pix_ff) * PRODW'(sum_ff[SUMW-1:LOW])) << LOW);
            default: ;
         endcase
      end
   end

   // Saturation and output register
   logic [VW-1:0]               val, limit;
   logic [blsc_pkg::BITS_W-1:0] bits;
   logic [blsc_pkg::PIX_W-1:0]  res;
   logic                        res_clip;

   always_comb begin
      if (cfg.pixel_bits == '0) bits = blsc_pkg::BITS_W'(1);
      else if (32'(cfg.pixel_bits) > blsc_pkg::MAX_BITS) bits = blsc_pkg::BITS_W'(blsc_pkg::MAX_BITS);
      else bits = cfg.pixel_bits;
      val   = VW'(prod_ff >> SH);
      limit = (VW'(1) << bits) - VW'(1);
      if (bypass_ff) begin
         res      = pix_ff;
         res_clip = 1'b0;
      end else if (val > limit) begin
         res      = blsc_pkg::PIX_W'(limit);
         res_clip = 1'b1;
      end else begin
         res      = blsc_pkg::PIX_W'(val);
         res_clip = 1'b0;
      end
   end

   logic rsp_valid_ff, rsp_valid_in;

   always_comb begin
      if (cmd.out_load) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
      else rsp_valid_in = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         pixel_out <= res;
         clipped   <= res_clip;
         frame_end <= fend_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign stat.bypass   = bypass;
   assign stat.out_full = rsp_valid_ff;

endmodule
`default_nettype wire

// File: sv/bayer_lens_shading_correction.sv
// A gain node write is taken while idle; a pass-through pixel goes straight to the output
// register; a corrected pixel passes through the bit-serial offset dividers, the address step,
// the four table reads and the multiply steps before it reaches the output register.
// Throughput: one pixel at a time, a new beat is taken once the previous pixel has reached the
// output register. Reset clears the row and column counters, the registers to their defaults and
// the handshakes; the gain table holds no reset value and must be written before use.
`timescale 1ns / 1ps
`default_nettype none
module bayer_lens_shading_correction #(
   parameter int MAX_GRID_CELLS   = blsc_pkg::MAX_GRID_CELLS_DEF,
   parameter int GAIN_FRAC_BITS   = blsc_pkg::GAIN_FRAC_BITS_DEF,
   parameter int OFFSET_FRAC_BITS = blsc_pkg::OFFSET_FRAC_BITS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // Input stream
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [10:0] node_index, [26:11] node_gain, [42:27] pixel_in, [47:43] zero
   input  wire logic [blsc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // [0] cmd
   input  wire logic                                req_tuser,
   // Result stream
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [15:0] pixel_out
   output logic      [blsc_pkg::PIX_W-1:0]          rsp_tdata,
   // [0] clipped
   output logic                                     rsp_tuser,
   output logic                                     rsp_tlast,
   // Register port
   input  wire logic                                csr_psel,
   input  wire logic                                csr_penable,
   input  wire logic                                csr_pwrite,
   input  wire logic [blsc_pkg::CFG_ADDR_W-1:0]     csr_paddr,
   input  wire logic [blsc_pkg::CFG_DATA_W-1:0]     csr_pwdata,
   output logic      [blsc_pkg::CFG_DATA_W-1:0]     csr_prdata,
   output logic                                     csr_pready
);

   // The register file lives here. Writes land on the access phase; reads are combinational.
   blsc_pkg::cfg_type cfg_ff, cfg_in;
   logic              cfg_wr;
   logic [2:0]        cfg_sel;

   assign csr_pready = 1'b1;
   assign cfg_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign cfg_sel    = csr_paddr[4:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (cfg_wr) begin
         unique case (cfg_sel)
            blsc_pkg::REG_ENABLE:        cfg_in.enable        = csr_pwdata[0];
            blsc_pkg::REG_BAYER_PATTERN: cfg_in.bayer_pattern = csr_pwdata[1:0];
            blsc_pkg::REG_FRAME_WIDTH:   cfg_in.frame_width   = csr_pwdata[blsc_pkg::DIM_W-1:0];
            blsc_pkg::REG_FRAME_HEIGHT:  cfg_in.frame_height  = csr_pwdata[blsc_pkg::DIM_W-1:0];
            blsc_pkg::REG_GRID_COLS:     cfg_in.grid_cols     = csr_pwdata[blsc_pkg::GRID_W-1:0];
            blsc_pkg::REG_GRID_ROWS:     cfg_in.grid_rows     = csr_pwdata[blsc_pkg::GRID_W-1:0];
            blsc_pkg::REG_PIXEL_BITS:    cfg_in.pixel_bits    = csr_pwdata[blsc_pkg::BITS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.enable        <= 1'b0;
         cfg_ff.bayer_pattern <= 2'd0;
         cfg_ff.frame_width   <= blsc_pkg::DIM_W'(1920);
         cfg_ff.frame_height  <= blsc_pkg::DIM_W'(1080);
         cfg_ff.grid_cols     <= blsc_pkg::GRID_W'(16);
         cfg_ff.grid_rows     <= blsc_pkg::GRID_W'(16);
         cfg_ff.pixel_bits    <= blsc_pkg::BITS_W'(12);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      csr_prdata = '0;
      unique case (cfg_sel)
         blsc_pkg::REG_ENABLE:        csr_prdata[0] = cfg_ff.enable;
         blsc_pkg::REG_BAYER_PATTERN: csr_prdata[1:0] = cfg_ff.bayer_pattern;
         blsc_pkg::REG_FRAME_WIDTH:   csr_prdata[blsc_pkg::DIM_W-1:0] = cfg_ff.frame_width;
         blsc_pkg::REG_FRAME_HEIGHT:  csr_prdata[blsc_pkg::DIM_W-1:0] = cfg_ff.frame_height;
         blsc_pkg::REG_GRID_COLS:     csr_prdata[blsc_pkg::GRID_W-1:0] = cfg_ff.grid_cols;
         blsc_pkg::REG_GRID_ROWS:     csr_prdata[blsc_pkg::GRID_W-1:0] = cfg_ff.grid_rows;
         blsc_pkg::REG_PIXEL_BITS:    csr_prdata[blsc_pkg::BITS_W-1:0] = cfg_ff.pixel_bits;
         default: ;
      endcase
   end

   // The controller sequences each corrected pixel through division, table reads and the multiply
   // steps; the datapath owns every arithmetic register, the gain table and the output beat.
   blsc_pkg::ctl_cmd_type  cmd;
   blsc_pkg::ctl_stat_type stat;

   blsc_ctrl #(
      .MAX_GRID_CELLS   (MAX_GRID_CELLS),
      .OFFSET_FRAC_BITS (OFFSET_FRAC_BITS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_cmd   (req_tuser),
      .req_ready (req_tready),
      .rsp_ready (rsp_tready),
      .stat      (stat),
      .cmd       (cmd)
   );

   blsc_dpath #(
      .MAX_GRID_CELLS   (MAX_GRID_CELLS),
      .GAIN_FRAC_BITS   (GAIN_FRAC_BITS),
      .OFFSET_FRAC_BITS (OFFSET_FRAC_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .cmd        (cmd),
      .stat       (stat),
      .node_index (req_tdata[10:0]),
      .node_gain  (req_tdata[26:11]),
      .pixel_in   (req_tdata[42:27]),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .pixel_out  (rsp_tdata),
      .clipped    (rsp_tuser),
      .frame_end  (rsp_tlast)
   );

endmodule
`default_nettype wire
